FILE: sv/hsjd_pkg.sv
// shared types and constants for the headset jack and hook key detector
package hsjd_pkg;

  // default mic line voltage width
  localparam int unsigned MV_BITS = 12;

  // register reset values
  localparam logic [7:0]  STABLE_COUNT_RESET   = 8'd15;
  localparam int unsigned MIC_LOW_RESET        = 1;
  localparam int unsigned MIC_HIGH_RESET       = 1900;
  localparam int unsigned PRESS_RESET          = 10;
  localparam logic [5:0]  WINDOW_RESET         = 6'd10;
  localparam logic [9:0]  SETTLE_RESET         = 10'd20;
  localparam logic        PLUGGED_LEVEL_RESET  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_STABLE_COUNT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIC_LOW       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MIC_HIGH      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESS         = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW        = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE        = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PLUGGED_LEVEL = 3'd6;

  typedef enum logic [1:0] {
    JACK_NONE   = 2'd0,
    JACK_MIC    = 2'd1,
    JACK_NO_MIC = 2'd2
  } jack_e;

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_ANSWER = 2'd1,
    KEY_REJECT = 2'd2
  } key_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_SETTLE   = 2'd2
  } phase_e;

  // detector state carried from tick to tick
  typedef struct packed {
    jack_e      reported_jack;
    phase_e     phase;
    logic [7:0] match_run;
    logic [7:0] mismatch_run;
    logic [9:0] settle_left;
    logic [5:0] window_pos;
    logic [5:0] pressed_count;
    logic       bias_on;
    logic       last_pressed;
  } state_t;

  localparam state_t STATE_RESET = '{
    reported_jack: JACK_NONE,
    phase:         PH_IDLE,
    match_run:     8'd0,
    mismatch_run:  8'd0,
    settle_left:   10'd0,
    window_pos:    6'd0,
    pressed_count: 6'd0,
    bias_on:       1'b0,
    last_pressed:  1'b0
  };

  // one result per tick
  typedef struct packed {
    logic  state_changed;
    logic  button_down;
    key_e  key_event;
    logic  mic_bias;
    jack_e jack_state;
  } result_t;

endpackage

FILE: sv/hsjd_step.sv
// next-state and result logic for one sample tick
module hsjd_step #(
  parameter int unsigned MV_BITS = hsjd_pkg::MV_BITS
) (
  input  hsjd_pkg::state_t  state_i,
  input  logic              jack_level_i,
  input  logic [MV_BITS-1:0] mic_mv_i,
  input  logic              call_active_i,
  input  logic [7:0]        stable_count_i,
  input  logic [MV_BITS-1:0] mic_low_mv_i,
  input  logic [MV_BITS-1:0] mic_high_mv_i,
  input  logic [MV_BITS-1:0] press_mv_i,
  input  logic [5:0]        window_samples_i,
  input  logic [9:0]        settle_ticks_i,
  input  logic              plugged_level_i,
  output hsjd_pkg::state_t  state_o,
  output hsjd_pkg::result_t result_o
);

  logic plugged, disagree, in_idle, want_plugged, deb_active, deb_match;
  logic deb_accept, deb_abandon, pressed, hook_scan, win_take, win_done;
  logic settle_done, classify_mic, changed;
  logic [7:0] match_base, mismatch_base, mismatch_inc;
  logic [5:0] pc_new, wp_new;
  hsjd_pkg::key_e   key;
  hsjd_pkg::state_t nxt;

  // jack debounce conditions
  assign plugged      = (jack_level_i == plugged_level_i);
  assign want_plugged = (state_i.reported_jack == hsjd_pkg::JACK_NONE);
  assign disagree     = plugged ? want_plugged : !want_plugged;
  assign in_idle      = (state_i.phase == hsjd_pkg::PH_IDLE);
  assign deb_active   = (state_i.phase == hsjd_pkg::PH_DEBOUNCE) || (in_idle && disagree);
  assign match_base    = in_idle ? 8'd0 : state_i.match_run;
  assign mismatch_base = in_idle ? 8'd0 : state_i.mismatch_run;
  assign mismatch_inc  = (mismatch_base != 8'hFF) ? mismatch_base + 8'd1 : mismatch_base;
  assign deb_match     = (plugged == want_plugged);
  assign deb_accept    = deb_active && deb_match && (match_base >= stable_count_i);
  assign deb_abandon   = deb_active && !deb_match && (mismatch_inc >= stable_count_i);

  // hook key window scan
  assign pressed   = (mic_mv_i <= press_mv_i);
  assign hook_scan = in_idle && !disagree && call_active_i &&
                     (state_i.reported_jack == hsjd_pkg::JACK_MIC);
  assign win_take  = hook_scan && ((state_i.window_pos != 6'd0) || pressed);
  assign pc_new    = state_i.pressed_count + {5'd0, pressed};
  assign wp_new    = state_i.window_pos + 6'd1;
  assign win_done  = win_take && (wp_new >= window_samples_i);

  // settling and classification
  assign settle_done  = (state_i.phase == hsjd_pkg::PH_SETTLE) &&
                        (state_i.settle_left == 10'd0);
  assign classify_mic = (mic_mv_i >= mic_low_mv_i) && (mic_mv_i <= mic_high_mv_i);

  // tick result flags
  always_comb begin
    key     = hsjd_pkg::KEY_NONE;
    changed = settle_done || (deb_accept && !want_plugged);
    if (win_done && (window_samples_i != 6'd0)) begin
      if (pc_new == window_samples_i) begin
        key = hsjd_pkg::KEY_REJECT;
      end else if (pc_new > 6'd1) begin
        key = hsjd_pkg::KEY_ANSWER;
      end
    end
  end

  // next state
  always_comb begin
    nxt = state_i;
    unique case (state_i.phase)
      hsjd_pkg::PH_IDLE: begin
        if (disagree) begin
          nxt.phase         = hsjd_pkg::PH_DEBOUNCE;
          nxt.window_pos    = 6'd0;
          nxt.pressed_count = 6'd0;
        end else if (hook_scan) begin
          nxt.last_pressed = pressed;
          if (win_done) begin
            nxt.window_pos    = 6'd0;
            nxt.pressed_count = 6'd0;
          end else if (win_take) begin
            nxt.window_pos    = wp_new;
            nxt.pressed_count = pc_new;
          end
        end else begin
          nxt.window_pos    = 6'd0;
          nxt.pressed_count = 6'd0;
        end
      end
      hsjd_pkg::PH_DEBOUNCE: begin
      end
      hsjd_pkg::PH_SETTLE: begin
        if (!settle_done) begin
          nxt.settle_left = state_i.settle_left - 10'd1;
        end else begin
          nxt.reported_jack = classify_mic ? hsjd_pkg::JACK_MIC : hsjd_pkg::JACK_NO_MIC;
          nxt.bias_on       = 1'b0;
          nxt.phase         = hsjd_pkg::PH_IDLE;
          nxt.window_pos    = 6'd0;
          nxt.pressed_count = 6'd0;
        end
      end
      default: begin
      end
    endcase

    // debounce counting, also on the tick that opens it
    if (deb_active) begin
      if (deb_match) begin
        nxt.mismatch_run = 8'd0;
        if (deb_accept) begin
          nxt.phase         = hsjd_pkg::PH_IDLE;
          nxt.match_run     = 8'd0;
          nxt.window_pos    = 6'd0;
          nxt.pressed_count = 6'd0;
          if (want_plugged) begin
            nxt.bias_on     = 1'b1;
            nxt.settle_left = settle_ticks_i;
            nxt.phase       = hsjd_pkg::PH_SETTLE;
          end else begin
            nxt.reported_jack = hsjd_pkg::JACK_NONE;
          end
        end else begin
          nxt.match_run = match_base + 8'd1;
        end
      end else begin
        nxt.match_run    = 8'd0;
        nxt.mismatch_run = mismatch_inc;
        if (deb_abandon) begin
          nxt.phase        = hsjd_pkg::PH_IDLE;
          nxt.mismatch_run = 8'd0;
        end
      end
    end

    // bias follows the call outside settling, but stays off on the tick that ends settling
    if ((nxt.phase != hsjd_pkg::PH_SETTLE) &&
        !(changed && (nxt.reported_jack != hsjd_pkg::JACK_NONE))) begin
      nxt.bias_on = (nxt.reported_jack == hsjd_pkg::JACK_MIC) && call_active_i;
    end
  end

  assign state_o = nxt;

  // result fields
  always_comb begin
    result_o.jack_state    = nxt.reported_jack;
    result_o.mic_bias      = nxt.bias_on;
    result_o.key_event     = key;
    result_o.button_down   = nxt.last_pressed;
    result_o.state_changed = changed;
  end

endmodule

FILE: sv/headset_jack_and_hook_key_detector_core.sv
// top level: headset jack debounce, mic classification and hook key detection
// an accepted sample request has its result in the output register in the next cycle
// throughput: one sample per cycle while the output is drained; the state register updates on every accepted request
// the input stays ready while a result waits, as long as the output is being drained
// reset (async, active low) clears detector state to no device and loads register defaults
module headset_jack_and_hook_key_detector_core #(
  parameter  int unsigned MV_BITS  = hsjd_pkg::MV_BITS,
  localparam int unsigned CfgDataW = (MV_BITS > 10) ? MV_BITS : 10,
  localparam int unsigned InDataW  = ((MV_BITS + 2 + 7) / 8) * 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hsjd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0]             cfg_data_i,
  // sample requests
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: jack_level, mic_mv, call_active, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result requests
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: jack_state, mic_bias, key_event, button_down, state_changed, zero fill
  output logic [7:0]          m_axis_tdata
);

  logic [7:0]         stable_count_q;
  logic [MV_BITS-1:0] mic_low_mv_q, mic_high_mv_q, press_mv_q;
  logic [5:0]         window_samples_q;
  logic [9:0]         settle_ticks_q;
  logic               plugged_level_q;

  hsjd_pkg::state_t  state_q, state_d;
  hsjd_pkg::result_t res_d, res_q;
  logic              out_valid_q, out_valid_d;
  logic              s_fire, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_count_q   <= hsjd_pkg::STABLE_COUNT_RESET;
      mic_low_mv_q     <= MV_BITS'(hsjd_pkg::MIC_LOW_RESET);
      mic_high_mv_q    <= MV_BITS'(hsjd_pkg::MIC_HIGH_RESET);
      press_mv_q       <= MV_BITS'(hsjd_pkg::PRESS_RESET);
      window_samples_q <= hsjd_pkg::WINDOW_RESET;
      settle_ticks_q   <= hsjd_pkg::SETTLE_RESET;
      plugged_level_q  <= hsjd_pkg::PLUGGED_LEVEL_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_addr_i)
        hsjd_pkg::REG_STABLE_COUNT:  stable_count_q   <= cfg_data_i[7:0];
        hsjd_pkg::REG_MIC_LOW:       mic_low_mv_q     <= cfg_data_i[MV_BITS-1:0];
        hsjd_pkg::REG_MIC_HIGH:      mic_high_mv_q    <= cfg_data_i[MV_BITS-1:0];
        hsjd_pkg::REG_PRESS:         press_mv_q       <= cfg_data_i[MV_BITS-1:0];
        hsjd_pkg::REG_WINDOW:        window_samples_q <= cfg_data_i[5:0];
        hsjd_pkg::REG_SETTLE:        settle_ticks_q   <= cfg_data_i[9:0];
        hsjd_pkg::REG_PLUGGED_LEVEL: plugged_level_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: the output register parts the two sides
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_valid_d   = s_fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  hsjd_step #(
    .MV_BITS(MV_BITS)
  ) u_step (
    .state_i          (state_q),
    .jack_level_i     (s_axis_tdata[0]),
    .mic_mv_i         (s_axis_tdata[MV_BITS:1]),
    .call_active_i    (s_axis_tdata[MV_BITS+1]),
    .stable_count_i   (stable_count_q),
    .mic_low_mv_i     (mic_low_mv_q),
    .mic_high_mv_i    (mic_high_mv_q),
    .press_mv_i       (press_mv_q),
    .window_samples_i (window_samples_q),
    .settle_ticks_i   (settle_ticks_q),
    .plugged_level_i  (plugged_level_q),
    .state_o          (state_d),
    .result_o         (res_d)
  );

  // detector state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsjd_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_fire) begin
        state_q <= state_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

`ifndef NO_ASSERTIONS
  // a reported change really changes the jack state
  a_change_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && res_d.state_changed) |-> (state_d.reported_jack != state_q.reported_jack))
    else $error("state_changed without a jack state change");

  // settling only follows a plug-in from no device
  a_settle_from_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == hsjd_pkg::PH_SETTLE) |-> (state_q.reported_jack == hsjd_pkg::JACK_NONE))
    else $error("settling with a device already reported");

  // key events only with a headset with mic and no jack change
  a_key_needs_mic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (res_d.key_event != hsjd_pkg::KEY_NONE)) |->
    ((res_d.jack_state == hsjd_pkg::JACK_MIC) && !res_d.state_changed))
    else $error("key event without headset with mic");

  // pressed count never runs ahead of the window position
  a_window_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pressed_count <= state_q.window_pos)
    else $error("pressed count exceeds window position");
`endif

endmodule
